### hw/rtl/lcdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdf_pkg
// Shared constants for the two-line display link framer.
// ----------------------------------------------------------------------------
package lcdf_pkg;

  localparam int LINE_CHARS = 16;
  localparam int STORE_DEPTH = 2 * LINE_CHARS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int FRAME_LEN = LINE_CHARS + 6;
  localparam int IDX_W = $clog2(FRAME_LEN);

  // frame byte positions
  localparam int POS_CTRL = 4;
  localparam int POS_TEXT = 5;
  localparam int POS_CHK = LINE_CHARS + 5;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] TX_HDR2 = 8'h1E;
  localparam logic [7:0] TX_HDR3 = 8'h12;
  localparam logic [7:0] RX_HDR2 = 8'h16;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [8:0] CHK_BASE = 9'h100;

  localparam int RX_KEEP = 6;
  localparam int RX_SAT = 16;
  localparam int RX_CNT_W = 5;
  localparam int RX_IDX_W = $clog2(RX_KEEP);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

endpackage
`default_nettype wire

### hw/rtl/lcdf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdf_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data that holds when read enable is low.
// ----------------------------------------------------------------------------
module lcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lcd_serial_link_framer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_serial_link_framer_top
// Two-line character display link framer: line stores, frame builder and
// button message receiver.
// ----------------------------------------------------------------------------
// A send item (mode 1) emits LINE_CHARS+6 frame bytes, one per cycle when
// out_ready stays high; the rate is set by the single read port of the line
// store, read one character ahead of the byte being emitted, and by the one
// 8-bit adder that accumulates the checksum byte by byte. The last byte of a
// valid six-byte button message also sends the block through a state that
// posts the button result. The line store is cleared at reset through
// per-entry valid bits, so no clearing pass is needed. Input is not taken
// while a frame or button result is in progress.
// ----------------------------------------------------------------------------
module lcd_serial_link_framer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic       line_sel,
  input  wire logic [3:0] column,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] rx_data,
  input  wire logic       rx_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic      [7:0] frame_data,
  output logic            last,
  output logic      [7:0] button_bits
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_BTN = 2'd2;

  logic [1:0] state, state_next;
  logic       backlight_on;
  logic       in_fire, slot_free, load;

  // frame sequencer
  logic [lcdf_pkg::IDX_W-1:0]  idx;
  logic                        line_q;
  logic [7:0]                  sum;
  logic                        ended;
  logic [7:0]                  byte_sel;
  logic [7:0]                  chr;
  logic                        ended_now;
  logic                        is_text, is_summed, is_last_byte, do_read;

  // line store
  logic [lcdf_pkg::STORE_DEPTH-1:0] vld_bits;
  logic                             vld_q;
  logic                             st_we;
  logic [lcdf_pkg::ADDR_W-1:0]      st_waddr, st_raddr;
  logic [7:0]                       st_rdata;

  // receiver
  logic [7:0]                     rx_store [lcdf_pkg::RX_KEEP];
  logic [lcdf_pkg::RX_CNT_W-1:0]  rx_count;
  logic [7:0]                     button_state;
  logic                           rx_match;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b0;
    end else if (cfg_we) begin
      backlight_on <= cfg_wdata;
    end
  end

  // ---- line store ----
  assign st_we = in_fire && (mode == lcdf_pkg::MODE_WRITE) &&
                 (32'(column) < lcdf_pkg::LINE_CHARS);
  assign st_waddr = lcdf_pkg::ADDR_W'(int'(line_sel) * lcdf_pkg::LINE_CHARS + int'(column));

  assign is_text      = (int'(idx) >= lcdf_pkg::POS_TEXT) && (int'(idx) < lcdf_pkg::POS_CHK);
  assign is_summed    = (int'(idx) >= lcdf_pkg::POS_CTRL) && (int'(idx) < lcdf_pkg::POS_CHK);
  assign is_last_byte = (int'(idx) == lcdf_pkg::POS_CHK);
  // fetch character k while emitting byte POS_CTRL+k
  assign do_read  = (state == ST_SEND) && slot_free &&
                    (int'(idx) >= lcdf_pkg::POS_CTRL) &&
                    (int'(idx) < lcdf_pkg::POS_CTRL + lcdf_pkg::LINE_CHARS);
  assign st_raddr = lcdf_pkg::ADDR_W'(int'(line_q) * lcdf_pkg::LINE_CHARS +
                                      int'(idx) - lcdf_pkg::POS_CTRL);

  lcdf_ram #(
    .WIDTH(8),
    .DEPTH(lcdf_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(char_code),
    .re   (do_read),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
    end else if (st_we) begin
      vld_bits[st_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      vld_q <= vld_bits[st_raddr];
    end
  end

  // ---- frame byte select ----
  assign chr       = vld_q ? st_rdata : 8'h00;
  assign ended_now = ended || (chr == 8'h00);

  always_comb begin
    priority if (int'(idx) == 0) begin
      byte_sel = lcdf_pkg::HDR0;
    end else if (int'(idx) == 1) begin
      byte_sel = lcdf_pkg::HDR1;
    end else if (int'(idx) == 2) begin
      byte_sel = lcdf_pkg::TX_HDR2;
    end else if (int'(idx) == 3) begin
      byte_sel = lcdf_pkg::TX_HDR3;
    end else if (int'(idx) == lcdf_pkg::POS_CTRL) begin
      byte_sel = {6'b0, backlight_on, line_q};
    end else if (is_text) begin
      byte_sel = ended_now ? lcdf_pkg::SPACE : chr;
    end else begin
      byte_sel = 8'(lcdf_pkg::CHK_BASE - {1'b0, sum});
    end
  end

  // ---- receiver check: current byte completes a six-byte burst ----
  assign rx_match = (int'(rx_count) == lcdf_pkg::RX_KEEP - 1) && rx_end &&
                    (rx_store[0] == lcdf_pkg::HDR0) && (rx_store[1] == lcdf_pkg::HDR1) &&
                    (rx_store[2] == lcdf_pkg::RX_HDR2) && (8'(rx_store[4] + rx_data) == 8'h00);

  always_ff @(posedge clk) begin
    if (in_fire && (mode == lcdf_pkg::MODE_RECV) &&
        (int'(rx_count) < lcdf_pkg::RX_KEEP)) begin
      rx_store[rx_count[lcdf_pkg::RX_IDX_W-1:0]] <= rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      button_state <= 8'h00;
    end else if (in_fire && (mode == lcdf_pkg::MODE_RECV)) begin
      if (rx_end) begin
        rx_count <= '0;
      end else if (int'(rx_count) < lcdf_pkg::RX_SAT) begin
        rx_count <= rx_count + 1'b1;
      end
      if (rx_match) begin
        button_state <= rx_store[4];
      end
    end
  end

  // ---- sequencer ----
  assign load = (state == ST_SEND || state == ST_BTN) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (mode == lcdf_pkg::MODE_SEND)) begin
          state_next = ST_SEND;
        end else if (in_fire && (mode == lcdf_pkg::MODE_RECV) && rx_match) begin
          state_next = ST_BTN;
        end
      end
      ST_SEND: begin
        if (slot_free && is_last_byte) begin
          state_next = ST_IDLE;
        end
      end
      ST_BTN: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (mode == lcdf_pkg::MODE_SEND)) begin
      idx    <= '0;
      sum    <= 8'h00;
      ended  <= 1'b0;
      line_q <= line_sel;
    end else if ((state == ST_SEND) && slot_free) begin
      idx <= idx + 1'b1;
      if (is_summed) begin
        sum <= sum + byte_sel;
      end
      if (is_text) begin
        ended <= ended_now;
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (state == ST_BTN) begin
        kind        <= lcdf_pkg::KIND_BUTTON;
        frame_data  <= 8'h00;
        last        <= 1'b1;
        button_bits <= button_state;
      end else begin
        kind        <= lcdf_pkg::KIND_FRAME;
        frame_data  <= byte_sel;
        last        <= is_last_byte;
        button_bits <= 8'h00;
      end
    end
  end

`ifndef SYNTHESIS
  a_btn_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == lcdf_pkg::KIND_BUTTON)) |-> (last && (frame_data == 8'h00)))
    else $error("button result malformed");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (int'(idx) <= lcdf_pkg::POS_CHK))
    else $error("frame index out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && (state == ST_SEND) && is_last_byte) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after last byte");
`endif

endmodule
`default_nettype wire

### bench/lcdf_link_checker.sv
// ----------------------------------------------------------------------------
// lcdf_link_checker
// Watches both channels and the backlight register port of the display link
// framer. It keeps its own copy of the line stores, the receive burst and the
// button state, works out the bytes and button updates that each accepted item
// should produce, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module lcdf_link_checker
  import lcdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] mode,
  input  logic       line_sel,
  input  logic [3:0] column,
  input  logic [7:0] char_code,
  input  logic [7:0] rx_data,
  input  logic       rx_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       kind,
  input  logic [7:0] frame_data,
  input  logic       last,
  input  logic [7:0] button_bits,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [7:0] buttons;
  } link_result_t;

  link_result_t        due_q[$];
  logic [7:0]          text_mem [STORE_DEPTH];
  logic [7:0]          rx_bytes [RX_KEEP];
  logic [RX_CNT_W-1:0] rx_len;
  logic [7:0]          buttons;
  logic                backlight;

  task automatic report(input string msg);
    $display("checker: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report($sformatf("%s is %02h, expected %02h", name, got, want));
  endtask

  function automatic link_result_t frame_byte(input logic [7:0] b, input logic fin);
    return '{KIND_FRAME, b, fin, 8'd0};
  endfunction

  task automatic predict_item(input logic [1:0] m, input logic sel, input logic [3:0] col,
                              input logic [7:0] ch, input logic [7:0] d, input logic fin);
    logic [7:0] ctl;
    logic [7:0] sum;
    logic [7:0] c;
    logic       blank;
    case (m)
      MODE_WRITE: begin
        if (col < LINE_CHARS) text_mem[sel * LINE_CHARS + col] = ch;
      end
      MODE_SEND: begin
        ctl = {7'd0, sel} + (backlight ? 8'd2 : 8'd0);
        due_q.push_back(frame_byte(HDR0, 1'b0));
        due_q.push_back(frame_byte(HDR1, 1'b0));
        due_q.push_back(frame_byte(TX_HDR2, 1'b0));
        due_q.push_back(frame_byte(TX_HDR3, 1'b0));
        due_q.push_back(frame_byte(ctl, 1'b0));
        sum = ctl;
        blank = 1'b0;
        // text ends at the first NUL; the rest of the line goes out as spaces
        for (int i = 0; i < LINE_CHARS; i++) begin
          c = text_mem[sel * LINE_CHARS + i];
          if (c == 8'd0) blank = 1'b1;
          if (blank) c = SPACE;
          sum = sum + c;
          due_q.push_back(frame_byte(c, 1'b0));
        end
        due_q.push_back(frame_byte(8'(CHK_BASE - {1'b0, sum}), 1'b1));
      end
      MODE_RECV: begin
        if (rx_len < RX_KEEP) rx_bytes[rx_len] = d;
        if (rx_len < RX_SAT) rx_len = rx_len + 1'b1;
        if (fin) begin
          if (rx_len == RX_KEEP && rx_bytes[0] == HDR0 && rx_bytes[1] == HDR1 &&
              rx_bytes[2] == RX_HDR2 && 8'(rx_bytes[4] + rx_bytes[5]) == 8'd0) begin
            buttons = rx_bytes[4];
            due_q.push_back('{KIND_BUTTON, 8'd0, 1'b1, buttons});
          end
          rx_len = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    link_result_t got;
    link_result_t want;
    if (rst) begin
      due_q.delete();
      foreach (text_mem[i]) text_mem[i] = 8'd0;
      foreach (rx_bytes[i]) rx_bytes[i] = 8'd0;
      rx_len = '0;
      buttons = 8'd0;
      backlight = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{kind, frame_data, last, button_bits};
        if (due_q.size() == 0) begin
          report($sformatf("result with none due: kind %0b data %02h last %0b buttons %02h",
                           kind, frame_data, last, button_bits));
        end else begin
          want = due_q.pop_front();
          check_field("kind", {7'd0, got.kind}, {7'd0, want.kind});
          check_field("frame_data", got.data, want.data);
          check_field("last", {7'd0, got.last}, {7'd0, want.last});
          check_field("button_bits", got.buttons, want.buttons);
        end
      end
      if (in_valid && in_ready)
        predict_item(mode, line_sel, column, char_code, rx_data, rx_end);
      if (cfg_we) backlight = cfg_wdata;
    end
    pending <= due_q.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the display link framer with character writes, line sends and
// receive bursts (good, corrupted, short and long), with random idling on
// both sides, a long receiver hold-off and backlight changes between phases.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import lcdf_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int FLAW_NONE = 0;
  localparam int FLAW_HEADER = 1;
  localparam int FLAW_CHECK = 2;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 86;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic       line_sel;
  logic [3:0] column;
  logic [7:0] char_code;
  logic [7:0] rx_data;
  logic       rx_end;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] frame_data;
  logic       last;
  logic [7:0] button_bits;
  int         errors;
  int         pending;

  int   items_done = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;

  lcd_serial_link_framer_top u_dut (.*);

  lcdf_link_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin : sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic offer(input logic [1:0] m, input logic sel, input logic [3:0] col,
                       input logic [7:0] ch, input logic [7:0] d, input logic fin);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    line_sel <= sel;
    column <= col;
    char_code <= ch;
    rx_data <= d;
    rx_end <= fin;
    do @(posedge clk); while (!in_ready);
    if (m != MODE_NONE) items_done++;
  endtask

  task automatic write_char(input logic sel, input logic [3:0] col, input logic [7:0] ch);
    offer(MODE_WRITE, sel, col, ch, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_line(input logic sel);
    offer(MODE_SEND, sel, 4'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic rx_byte(input logic [7:0] d, input logic fin);
    offer(MODE_RECV, 1'($urandom), 4'($urandom), 8'($urandom), d, fin);
  endtask

  task automatic write_random();
    write_char(1'($urandom), 4'($urandom),
               ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom));
  endtask

  // one burst: a button message of len bytes, optionally corrupted, with the
  // odd write or send slipped in between bytes
  task automatic rx_message(input int len, input int flaw);
    logic [7:0] msg [20];
    logic [7:0] b;
    foreach (msg[i]) msg[i] = 8'($urandom);
    b = 8'($urandom);
    msg[0] = HDR0;
    msg[1] = HDR1;
    msg[2] = RX_HDR2;
    msg[4] = b;
    msg[5] = 8'd0 - b;
    if (flaw == FLAW_HEADER) msg[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
    else if (flaw == FLAW_CHECK) msg[5] ^= 8'($urandom_range(255, 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1) == 1) send_line(1'($urandom));
        else write_random();
      end
      rx_byte(msg[i], i == len - 1);
    end
  endtask

  task automatic set_backlight(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering until every result due has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stim
    int r;
    int len;
    int target;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    mode = MODE_WRITE;
    line_sel = 1'b0;
    column = 4'd0;
    char_code = 8'd0;
    rx_data = 8'd0;
    rx_end = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_backlight(1'b0);

    // directed
    send_line(1'b1);
    write_char(1'b0, 4'd0, 8'hFF);
    write_char(1'b1, 4'd15, 8'h41);
    offer(MODE_NONE, 1'b1, 4'd15, 8'hFF, 8'hFF, 1'b1);
    rx_byte(HDR0, 1'b0);
    write_char(1'b0, 4'd1, 8'h00);
    rx_byte(HDR1, 1'b0);
    send_line(1'b0);
    rx_byte(RX_HDR2, 1'b0);
    rx_byte(8'h3C, 1'b0);
    rx_byte(8'h80, 1'b0);
    rx_byte(8'h80, 1'b1);
    rx_message(7, FLAW_NONE);
    rx_message(6, FLAW_CHECK);
    drain();
    set_backlight(1'b1);
    send_line(1'b1);

    target = items_done;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_backlight(ph % 2 == 1);
      no_idle = (ph == 1);
      if (ph == 2) begin
        hold_req = 1'b1;
        repeat (3) send_line(1'($urandom));
      end
      target += PHASE_ITEMS;
      while (items_done < target) begin
        r = $urandom_range(99);
        if (r < 38) begin
          write_random();
        end else if (r < 52) begin
          send_line(1'($urandom));
        end else if (r < 55) begin
          offer(MODE_NONE, 1'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
        end else begin
          r = $urandom_range(99);
          if (r < 65) begin
            rx_message(6, FLAW_NONE);
          end else if (r < 75) begin
            rx_message(6, FLAW_HEADER);
          end else if (r < 85) begin
            rx_message(6, FLAW_CHECK);
          end else begin
            // any length but six, up to past the count saturation
            len = $urandom_range(19, 1);
            if (len >= RX_KEEP) len++;
            rx_message(len, FLAW_NONE);
          end
        end
      end
    end
    no_idle = 1'b0;
    drain();

    if (errors == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

### files.f
hw/rtl/lcdf_pkg.sv
hw/rtl/lcdf_ram.sv
hw/rtl/lcd_serial_link_framer_top.sv
bench/lcdf_link_checker.sv
bench/testbench.sv
